>>> rtl/dcpp_pkg.sv
package dcpp_pkg;

  localparam int TICKS_PER_US    = 60;
  localparam int US_PER_MS       = 1000;
  localparam int PCT_MAX         = 100;
  localparam int MS_MIN          = 1;
  localparam int MS_MAX          = 100;
  localparam int PERIOD_MS_RESET = 20;

  localparam int MODE_W  = 2;
  localparam int PCT_W   = 8;
  localparam int PCTS_W  = 7;
  localparam int MS_W    = 7;
  localparam int CNT_W   = 23;
  localparam int STEP_W  = 16;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;

  localparam logic REG_PERIOD_MS = 1'b0;

  // counts per millisecond and per percent of a millisecond
  localparam logic [CNT_W-1:0]  COUNT_PER_MS = CNT_W'(TICKS_PER_US * US_PER_MS);
  localparam logic [STEP_W-1:0] STEP_PER_MS  = STEP_W'(TICKS_PER_US * US_PER_MS / PCT_MAX);

  localparam logic [MS_W-1:0]   MS_RESET    = MS_W'(PERIOD_MS_RESET);
  localparam logic [CNT_W-1:0]  COUNT_RESET =
    CNT_W'(TICKS_PER_US * US_PER_MS * PERIOD_MS_RESET);
  localparam logic [STEP_W-1:0] STEP_RESET  =
    STEP_W'(TICKS_PER_US * US_PER_MS / PCT_MAX * PERIOD_MS_RESET);

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic             left_on;
    logic             right_on;
    logic [CNT_W-1:0] count_now;
    logic             period_start;
  } res_t;

endpackage

>>> rtl/dcpp_cmd_if.sv
interface dcpp_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [dcpp_pkg::MODE_W-1:0]   mode;
  logic [dcpp_pkg::PCT_W-1:0]    duty_percent;

  modport source(output valid, output mode, output duty_percent, input ready);
  modport sink(input valid, input mode, input duty_percent, output ready);
endinterface

>>> rtl/dcpp_res_if.sv
interface dcpp_res_if;
  logic                          valid;
  logic                          ready;
  logic                          left_on;
  logic                          right_on;
  logic [dcpp_pkg::CNT_W-1:0]    count_now;
  logic                          period_start;

  modport source(output valid, output left_on, output right_on, output count_now,
                 output period_start, input ready);
  modport sink(input valid, input left_on, input right_on, input count_now,
               input period_start, output ready);
endinterface

>>> rtl/dcpp_cfg.sv
module dcpp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcpp_pkg::ADDR_W-1:0]   paddr,
  input  logic [dcpp_pkg::DATA_W-1:0]   pwdata,
  output logic [dcpp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dcpp_pkg::cfg_t                cfg
);

  logic [dcpp_pkg::MS_W-1:0] period_ms;
  logic [dcpp_pkg::MS_W-1:0] ms_raw;
  logic [dcpp_pkg::MS_W-1:0] ms_clamped;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == dcpp_pkg::REG_PERIOD_MS);
  assign ms_raw = pwdata[dcpp_pkg::MS_W-1:0];

  always_comb begin
    ms_clamped = ms_raw;
    if (ms_raw < dcpp_pkg::MS_W'(dcpp_pkg::MS_MIN)) begin
      ms_clamped = dcpp_pkg::MS_W'(dcpp_pkg::MS_MIN);
    end else if (ms_raw > dcpp_pkg::MS_W'(dcpp_pkg::MS_MAX)) begin
      ms_clamped = dcpp_pkg::MS_W'(dcpp_pkg::MS_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms  <= dcpp_pkg::MS_RESET;
      cfg.count  <= dcpp_pkg::COUNT_RESET;
      cfg.step   <= dcpp_pkg::STEP_RESET;
    end else if (wr_en) begin
      period_ms  <= ms_raw;
      cfg.count  <= dcpp_pkg::CNT_W'(ms_clamped) * dcpp_pkg::COUNT_PER_MS;
      cfg.step   <= dcpp_pkg::STEP_W'(ms_clamped) * dcpp_pkg::STEP_PER_MS;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == dcpp_pkg::REG_PERIOD_MS) begin
      prdata = dcpp_pkg::DATA_W'(period_ms);
    end
  end

endmodule

>>> rtl/dcpp_core.sv
module dcpp_core (
  input  logic              clk,
  input  logic              rst,
  dcpp_cmd_if.sink          cmd,
  input  logic              space,
  input  dcpp_pkg::cfg_t    cfg,
  output logic              push,
  output dcpp_pkg::res_t    res
);

  logic [dcpp_pkg::CNT_W-1:0]  period_counter;
  logic [dcpp_pkg::CNT_W-1:0]  left_shadow;
  logic [dcpp_pkg::CNT_W-1:0]  right_shadow;
  logic [dcpp_pkg::CNT_W-1:0]  left_active;
  logic [dcpp_pkg::CNT_W-1:0]  right_active;

  logic [dcpp_pkg::CNT_W-1:0]  period_counter_next;
  logic [dcpp_pkg::CNT_W-1:0]  left_active_next;
  logic [dcpp_pkg::CNT_W-1:0]  right_active_next;
  logic [dcpp_pkg::PCTS_W-1:0] pct_sat;
  logic [dcpp_pkg::CNT_W-1:0]  match;
  logic                        wrap;
  logic                        accept;

  assign cmd.ready = space;
  assign accept    = cmd.valid && space;

  assign pct_sat = (cmd.duty_percent >= dcpp_pkg::PCT_W'(dcpp_pkg::PCT_MAX)) ?
                   dcpp_pkg::PCTS_W'(dcpp_pkg::PCT_MAX) :
                   cmd.duty_percent[dcpp_pkg::PCTS_W-1:0];

  // step * 100 equals the period count, so full duty is count + 1
  always_comb begin
    if (cmd.duty_percent >= dcpp_pkg::PCT_W'(dcpp_pkg::PCT_MAX)) begin
      match = cfg.count + dcpp_pkg::CNT_W'(1);
    end else begin
      match = dcpp_pkg::CNT_W'(cfg.step) * dcpp_pkg::CNT_W'(pct_sat);
    end
  end

  assign wrap = (cmd.mode == dcpp_pkg::MODE_TICK) && (period_counter >= cfg.count);

  always_comb begin
    period_counter_next = period_counter;
    left_active_next    = left_active;
    right_active_next   = right_active;
    if (cmd.mode == dcpp_pkg::MODE_TICK) begin
      if (wrap) begin
        period_counter_next = '0;
        left_active_next    = left_shadow;
        right_active_next   = right_shadow;
      end else begin
        period_counter_next = period_counter + dcpp_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_counter <= '0;
      left_shadow    <= '0;
      right_shadow   <= '0;
      left_active    <= '0;
      right_active   <= '0;
      push           <= 1'b0;
    end else begin
      push <= accept;
      if (accept) begin
        period_counter <= period_counter_next;
        left_active    <= left_active_next;
        right_active   <= right_active_next;
        unique case (cmd.mode)
          dcpp_pkg::MODE_LEFT:  left_shadow  <= match;
          dcpp_pkg::MODE_RIGHT: right_shadow <= match;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.left_on      <= period_counter_next < left_active_next;
      res.right_on     <= period_counter_next < right_active_next;
      res.count_now    <= period_counter_next;
      res.period_start <= wrap;
    end
  end

endmodule

>>> rtl/dcpp_out_buf.sv
module dcpp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dcpp_pkg::res_t    wdata,
  output logic              space,
  dcpp_res_if.source        res
);

  // two entries: one word in flight from the core plus one waiting at the port
  dcpp_pkg::res_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic [1:0]     fill_next;
  logic           pop;
  dcpp_pkg::res_t head;

  assign pop   = res.valid && res.ready;
  // the core registers one word before pushing it, so reserve room for it
  assign space = (fill == 2'd0) || ((fill == 2'd1) && !push) || 
                 ((fill == 2'd1) && pop) || ((fill == 2'd2) && pop && !push);

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 2'd1;
    end else if (pop && !push) begin
      fill_next = fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  assign head             = entry[rd_ptr];
  assign res.valid        = fill != 2'd0;
  assign res.left_on      = head.left_on;
  assign res.right_on     = head.right_on;
  assign res.count_now    = head.count_now;
  assign res.period_start = head.period_start;

endmodule

>>> rtl/dual_channel_percent_pwm_core.sv
// channel  dir  payload                                         ready
// cmd      in   mode[1:0], duty_percent[7:0]                    high while result queue has room
// res      out  left_on, right_on, count_now[22:0], period_start valid while queue holds a word
// apb      in   period_ms at byte address 0                     pready always high
//
// One word per cycle while cmd is ready; each result is registered in the core, then queued.
// Tick, duty scaling and level compare are done in the cycle the word is taken.
// A two-entry result queue decouples the sides: cmd stays ready while res stalls,
// until both entries are held or one is held and another word is on its way in.
// rst is synchronous: counter and match registers clear, period_ms returns to 20.
module dual_channel_percent_pwm_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcpp_pkg::ADDR_W-1:0]   paddr,
  input  logic [dcpp_pkg::DATA_W-1:0]   pwdata,
  output logic [dcpp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  dcpp_cmd_if.sink                      cmd,
  dcpp_res_if.source                    res
);

  dcpp_pkg::cfg_t cfg;
  dcpp_pkg::res_t core_res;
  logic           push;
  logic           space;

  dcpp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcpp_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .space (space),
    .cfg   (cfg),
    .push  (push),
    .res   (core_res)
  );

  dcpp_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (core_res),
    .space (space),
    .res   (res)
  );

endmodule
